@@ design/kf_pkg.sv @@
// ----------------------------------------------------------------------------
// kf_pkg
// Shared widths, reset values, register codes and control types for the
// scalar Kalman filter.
// ----------------------------------------------------------------------------
package kf_pkg;

    localparam int DATA_W   = 32;
    localparam int NOISE_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = FRAC_W + 1;
    localparam int DEN_W    = DATA_W + 1;
    localparam int REM_W    = DEN_W + 1;
    localparam int INNOV_W  = DATA_W + 1;
    localparam int ACCG_W   = DATA_W + FRAC_W;
    localparam int ACCX_W   = ACCG_W + 1;
    localparam int CNT_W    = $clog2(GAIN_W + 1);
    localparam int ADDR_W   = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(GAIN_W);
    localparam logic [DATA_W-1:0]  COV_RESET = DATA_W'(32'h0001_0000);
    localparam logic [NOISE_W-1:0] Q_RESET   = NOISE_W'(655);
    localparam logic [NOISE_W-1:0] R_RESET   = NOISE_W'(22938);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DONE
    } kf_state_t;

    typedef enum logic {
        REG_PROCESS_NOISE     = 1'b0,
        REG_MEASUREMENT_NOISE = 1'b1
    } kf_reg_t;

    typedef struct packed {
        logic start;
        logic div_step;
        logic mac_step;
    } kf_ctl_t;

endpackage

@@ design/kf_cfg.sv @@
// ----------------------------------------------------------------------------
// kf_cfg
// APB register file holding the process and measurement noise variances.
// ----------------------------------------------------------------------------
module kf_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kf_pkg::ADDR_W-1:0]       paddr,
    input  logic [kf_pkg::PDATA_W-1:0]      pwdata,
    output logic [kf_pkg::PDATA_W-1:0]      prdata,
    output logic                            pready,
    output logic [kf_pkg::NOISE_W-1:0]      process_noise,
    output logic [kf_pkg::NOISE_W-1:0]      measurement_noise
);

    logic [kf_pkg::NOISE_W-1:0] q_reg;
    logic [kf_pkg::NOISE_W-1:0] r_reg;
    logic                       wr_en;
    kf_pkg::kf_reg_t            sel;

    assign wr_en  = psel && penable && pwrite;
    assign sel    = kf_pkg::kf_reg_t'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= kf_pkg::Q_RESET;
            r_reg <= kf_pkg::R_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel)
                kf_pkg::REG_PROCESS_NOISE:     q_reg <= pwdata[kf_pkg::NOISE_W-1:0];
                kf_pkg::REG_MEASUREMENT_NOISE: r_reg <= pwdata[kf_pkg::NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            kf_pkg::REG_PROCESS_NOISE:
                prdata = kf_pkg::PDATA_W'(q_reg);
            kf_pkg::REG_MEASUREMENT_NOISE:
                prdata = kf_pkg::PDATA_W'(r_reg);
            default:
                prdata = '0;
        endcase
    end

    assign process_noise     = q_reg;
    assign measurement_noise = r_reg;

endmodule

@@ design/kf_div.sv @@
// ----------------------------------------------------------------------------
// kf_div
// Restoring divider that produces the gain one bit per cycle, most
// significant bit first.
// ----------------------------------------------------------------------------
module kf_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  kf_pkg::kf_ctl_t               ctl,
    input  logic [kf_pkg::DATA_W-1:0]     pred,
    input  logic [kf_pkg::DEN_W-1:0]      den,
    output logic                          qbit
);

    logic [kf_pkg::REM_W-1:0] rem_reg;
    logic [kf_pkg::DEN_W-1:0] den_reg;
    logic                     zero_reg;
    logic                     first_reg;
    logic                     qbit_reg;

    logic [kf_pkg::REM_W-1:0] cand;
    logic [kf_pkg::REM_W-1:0] den_ext;
    logic [kf_pkg::REM_W-1:0] diff;
    logic                     ge;

    assign den_ext = {1'b0, den_reg};
    assign cand    = first_reg ? rem_reg : {rem_reg[kf_pkg::REM_W-2:0], 1'b0};
    assign ge      = cand >= den_ext;
    assign diff    = cand - den_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
            qbit_reg  <= 1'b0;
        end
        else if (ctl.start)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.div_step)
        begin
            first_reg <= 1'b0;
            qbit_reg  <= zero_reg ? first_reg : ge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg  <= {2'b00, pred};
            den_reg  <= den;
            zero_reg <= (den == '0);
        end
        else if (ctl.div_step)
        begin
            rem_reg <= ge ? diff : cand;
        end
    end

    assign qbit = qbit_reg;

endmodule

@@ design/kf_mac.sv @@
// ----------------------------------------------------------------------------
// kf_mac
// Bit-serial shift-and-add unit that forms gain times innovation and
// gain times predicted covariance as the gain bits arrive.
// ----------------------------------------------------------------------------
module kf_mac
(
    input  logic                                 clk,
    input  kf_pkg::kf_ctl_t                      ctl,
    input  logic                                 qbit,
    input  logic signed [kf_pkg::INNOV_W-1:0]    innov,
    input  logic        [kf_pkg::DATA_W-1:0]     pred,
    output logic signed [kf_pkg::ACCX_W-1:0]     acc_x,
    output logic        [kf_pkg::ACCG_W-1:0]     acc_g
);

    logic signed [kf_pkg::ACCX_W-1:0] acc_x_reg;
    logic        [kf_pkg::ACCG_W-1:0] acc_g_reg;
    logic signed [kf_pkg::ACCX_W-1:0] innov_ext;
    logic        [kf_pkg::ACCG_W-1:0] pred_ext;

    assign innov_ext = {{(kf_pkg::ACCX_W - kf_pkg::INNOV_W){innov[kf_pkg::INNOV_W-1]}}, innov};
    assign pred_ext  = kf_pkg::ACCG_W'(pred);

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_x_reg <= '0;
            acc_g_reg <= '0;
        end
        else if (ctl.mac_step)
        begin
            acc_x_reg <= {acc_x_reg[kf_pkg::ACCX_W-2:0], 1'b0} + (qbit ? innov_ext : '0);
            acc_g_reg <= {acc_g_reg[kf_pkg::ACCG_W-2:0], 1'b0} + (qbit ? pred_ext : '0);
        end
    end

    assign acc_x = acc_x_reg;
    assign acc_g = acc_g_reg;

endmodule

@@ design/scalar_kalman_filter.sv @@
// A request is accepted only in the idle state; the input then stalls until
// its result is committed, which waits while an earlier result is stalled.
// The work is set by the 17-step gain divider with the multiplier one bit behind it.
// A finished result waits in the output register while the next request runs.
// Reset is asynchronous and active low: estimate 0, covariance 1.0,
// noise registers at their defaults, no result pending.
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter with a constant-state model in fixed point,
// built from a serial divider and a serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
module scalar_kalman_filter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kf_pkg::ADDR_W-1:0]           paddr,
    input  logic [kf_pkg::PDATA_W-1:0]          pwdata,
    output logic [kf_pkg::PDATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [kf_pkg::DATA_W-1:0]    sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [kf_pkg::DATA_W-1:0]    estimate
);

    logic [kf_pkg::NOISE_W-1:0] q_val;
    logic [kf_pkg::NOISE_W-1:0] r_val;

    kf_pkg::kf_state_t state_reg, state_next;
    logic [kf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    kf_pkg::kf_ctl_t ctl;
    logic commit;
    logic accept;

    logic signed [kf_pkg::DATA_W-1:0]  est_reg;
    logic        [kf_pkg::DATA_W-1:0]  cov_reg;
    logic        [kf_pkg::DATA_W-1:0]  pred_reg;
    logic signed [kf_pkg::INNOV_W-1:0] innov_reg;
    logic                              out_valid_reg;
    logic signed [kf_pkg::DATA_W-1:0]  out_reg;

    logic [kf_pkg::DATA_W:0]           pred_sum;
    logic [kf_pkg::DATA_W-1:0]         pred_sat;
    logic signed [kf_pkg::INNOV_W-1:0] innov_val;
    logic [kf_pkg::DEN_W-1:0]          den;
    logic                              qbit;
    logic signed [kf_pkg::ACCX_W-1:0]  acc_x;
    logic        [kf_pkg::ACCG_W-1:0]  acc_g;
    logic signed [kf_pkg::DATA_W-1:0]  new_est;
    logic        [kf_pkg::ACCG_W-1:0]  cov_diff;

    kf_cfg u_cfg
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .process_noise     (q_val),
        .measurement_noise (r_val)
    );

    kf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pred  (pred_reg),
        .den   (den),
        .qbit  (qbit)
    );

    kf_mac u_mac
    (
        .clk   (clk),
        .ctl   (ctl),
        .qbit  (qbit),
        .innov (innov_reg),
        .pred  (pred_reg),
        .acc_x (acc_x),
        .acc_g (acc_g)
    );

    assign in_stall  = (state_reg != kf_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign estimate  = out_reg;

    assign pred_sum  = {1'b0, cov_reg} + (kf_pkg::DATA_W + 1)'(q_val);
    assign pred_sat  = pred_sum[kf_pkg::DATA_W] ? '1 : pred_sum[kf_pkg::DATA_W-1:0];
    assign innov_val = {sample[kf_pkg::DATA_W-1], sample} - {est_reg[kf_pkg::DATA_W-1], est_reg};
    assign den       = {1'b0, pred_reg} + kf_pkg::DEN_W'(r_val);

    assign new_est   = est_reg + acc_x[kf_pkg::ACCG_W-1:kf_pkg::FRAC_W];
    assign cov_diff  = {pred_reg, {kf_pkg::FRAC_W{1'b0}}} - acc_g;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ctl          = '0;
        commit       = 1'b0;
        unique case (state_reg)
            kf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = kf_pkg::ST_PREP;
                end
            end
            kf_pkg::ST_PREP:
            begin
                ctl.start  = 1'b1;
                cnt_next   = '0;
                state_next = kf_pkg::ST_RUN;
            end
            kf_pkg::ST_RUN:
            begin
                ctl.div_step = (cnt_reg != kf_pkg::LAST_STEP);
                ctl.mac_step = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == kf_pkg::LAST_STEP)
                begin
                    state_next = kf_pkg::ST_DONE;
                end
            end
            kf_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    commit     = 1'b1;
                    state_next = kf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            est_reg       <= '0;
            cov_reg       <= kf_pkg::COV_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                est_reg       <= new_est;
                cov_reg       <= cov_diff[kf_pkg::ACCG_W-1:kf_pkg::FRAC_W];
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pred_reg  <= pred_sat;
            innov_reg <= innov_val;
        end
        if (commit)
        begin
            out_reg <= new_est;
        end
    end

endmodule

@@ design/kf_checker.sv @@
// ----------------------------------------------------------------------------
// kf_checker
// Port-level checks on the request and result channels of the filter.
// ----------------------------------------------------------------------------
module kf_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [kf_pkg::DATA_W-1:0]         estimate
);

    // A request keeps the input side busy for the whole computation.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input not stalled after a request was accepted");

    a_busy_long: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##10 in_stall
    ) else $error("input released before the computation could finish");

    // A new result only appears at the end of a computation.
    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall)
    ) else $error("result appeared without a request in progress");

    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(estimate))
    ) else $error("stalled result changed or was dropped");

endmodule

bind scalar_kalman_filter kf_checker u_kf_checker (.*);

@@ bench/scalar_kalman_filter_test.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_test
// Self-checking bench for the scalar Kalman filter. A scoreboard class keeps
// its own fixed-point copy of the estimate, the covariance and the noise
// registers, predicts every estimate and checks each result in order. Plain
// tasks drive the request channel and the APB port, with random gaps and
// output stalls, over directed corner cases and random noise settings.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 200;
    localparam int SETTLE_CYCLES = 30;
    localparam logic [kf_pkg::GAIN_W-1:0] GAIN_ONE =
        kf_pkg::GAIN_W'(1 << kf_pkg::FRAC_W);

    class estimate_tracker;
        logic [kf_pkg::NOISE_W-1:0]       q_var;
        logic [kf_pkg::NOISE_W-1:0]       r_var;
        logic signed [kf_pkg::DATA_W-1:0] level;
        logic [kf_pkg::DATA_W-1:0]        covariance;
        logic signed [kf_pkg::DATA_W-1:0] pending[$];
        int                               mismatches;
        int                               samples_seen;
        int                               estimates_seen;

        function new();
            q_var          = kf_pkg::Q_RESET;
            r_var          = kf_pkg::R_RESET;
            level          = '0;
            covariance     = kf_pkg::COV_RESET;
            mismatches     = 0;
            samples_seen   = 0;
            estimates_seen = 0;
        endfunction

        function void set_noise(input kf_pkg::kf_reg_t idx,
                                input logic [kf_pkg::PDATA_W-1:0] value);
            if (idx == kf_pkg::REG_PROCESS_NOISE)
                q_var = value[kf_pkg::NOISE_W-1:0];
            else
                r_var = value[kf_pkg::NOISE_W-1:0];
        endfunction

        function logic [kf_pkg::NOISE_W-1:0] noise_of(input kf_pkg::kf_reg_t idx);
            return (idx == kf_pkg::REG_PROCESS_NOISE) ? q_var : r_var;
        endfunction

        function void absorb_sample(input logic signed [kf_pkg::DATA_W-1:0] z);
            logic [kf_pkg::DEN_W-1:0]  pred_cov;
            logic [kf_pkg::DEN_W-1:0]  den;
            logic [63:0]               quotient;
            logic [kf_pkg::GAIN_W-1:0] gain;
            longint                    innov;
            longint                    step;
            logic [63:0]               shrunk;

            pred_cov = {1'b0, covariance} + kf_pkg::DEN_W'(q_var);
            if (pred_cov[kf_pkg::DATA_W])
                pred_cov = {1'b0, {kf_pkg::DATA_W{1'b1}}};
            den = pred_cov + kf_pkg::DEN_W'(r_var);
            if (den == '0)
            begin
                gain = GAIN_ONE;
            end
            else
            begin
                quotient = (64'(pred_cov) << kf_pkg::FRAC_W) / 64'(den);
                gain = (quotient > 64'(GAIN_ONE)) ? GAIN_ONE
                                                  : quotient[kf_pkg::GAIN_W-1:0];
            end
            innov      = longint'(z) - longint'(level);
            step       = (innov * longint'({47'd0, gain})) >>> kf_pkg::FRAC_W;
            level      = kf_pkg::DATA_W'(longint'(level) + step);
            shrunk     = (64'(pred_cov) * (64'(GAIN_ONE) - 64'(gain))) >> kf_pkg::FRAC_W;
            covariance = shrunk[kf_pkg::DATA_W-1:0];
            pending.push_back(level);
            samples_seen++;
        endfunction

        function void compare_estimate(input logic signed [kf_pkg::DATA_W-1:0] actual);
            logic signed [kf_pkg::DATA_W-1:0] wanted;

            estimates_seen++;
            if (pending.size() == 0)
            begin
                $error("estimate: no request outstanding, expected none, actual %0d", actual);
                mismatches++;
            end
            else
            begin
                wanted = pending.pop_front();
                if (actual !== wanted)
                begin
                    $error("estimate: expected %0d, actual %0d", wanted, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             psel      = 1'b0;
    logic                             penable   = 1'b0;
    logic                             pwrite    = 1'b0;
    logic [kf_pkg::ADDR_W-1:0]        paddr     = '0;
    logic [kf_pkg::PDATA_W-1:0]       pwdata    = '0;
    logic [kf_pkg::PDATA_W-1:0]       prdata;
    logic                             pready;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic signed [kf_pkg::DATA_W-1:0] sample    = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic signed [kf_pkg::DATA_W-1:0] estimate;

    estimate_tracker tracker = new();
    bit              sender_steady   = 1'b0;
    bit              receiver_steady = 1'b0;
    int              stall_left      = 0;
    int              quiet_cycles    = 0;
    int              settings_used   = 1;

    scalar_kalman_filter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .estimate  (estimate)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic logic [kf_pkg::ADDR_W-1:0] reg_addr(input kf_pkg::kf_reg_t idx);
        return kf_pkg::ADDR_W'(4 * int'(idx));
    endfunction

    function automatic logic [kf_pkg::PDATA_W-1:0] pick_noise();
        logic [kf_pkg::NOISE_W-1:0] low;

        case ($urandom_range(0, 4))
            0:       low = '0;
            1:       low = '1;
            2:       low = kf_pkg::NOISE_W'($urandom_range(0, 65535));
            default: low = kf_pkg::NOISE_W'($urandom);
        endcase
        return {8'($urandom), low};
    endfunction

    function automatic logic signed [kf_pkg::DATA_W-1:0] pick_sample();
        int offset;

        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4: return kf_pkg::DATA_W'($urandom);
            default:
            begin
                offset = int'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
                return tracker.level + kf_pkg::DATA_W'(offset);
            end
        endcase
    endfunction

    // Every request yields one estimate, so an empty scoreboard means idle.
    task automatic drain_estimates();
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input kf_pkg::kf_reg_t idx, input bit is_write,
                              input logic [kf_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= reg_addr(idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (is_write)
        begin
            tracker.set_noise(idx, value);
        end
        else if (prdata !== kf_pkg::PDATA_W'(tracker.noise_of(idx)))
        begin
            $error("%s: expected %h, actual %h", idx.name(),
                   kf_pkg::PDATA_W'(tracker.noise_of(idx)), prdata);
            tracker.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_noise_pair(input logic [kf_pkg::PDATA_W-1:0] q,
                                  input logic [kf_pkg::PDATA_W-1:0] r);
        drain_estimates();
        apb_access(kf_pkg::REG_PROCESS_NOISE, 1'b1, q);
        apb_access(kf_pkg::REG_MEASUREMENT_NOISE, 1'b1, r);
        apb_access(kf_pkg::REG_PROCESS_NOISE, 1'b0, '0);
        apb_access(kf_pkg::REG_MEASUREMENT_NOISE, 1'b0, '0);
        settings_used++;
    endtask

    task automatic send_sample(input logic signed [kf_pkg::DATA_W-1:0] z);
        int gap;

        if ($urandom_range(0, 39) == 0)
            sender_steady = !sender_steady;
        gap = draw_gap(sender_steady);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.absorb_sample(z);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.compare_estimate(estimate);
            if ($urandom_range(0, 39) == 0)
                receiver_steady = !receiver_steady;
            stall_left = draw_gap(receiver_steady);
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            if (out_valid)
                stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("scalar_kalman_filter_test: FAIL");
        $finish;
    end

    initial
    begin
        logic [kf_pkg::DATA_W-1:0] corner[$];
        int                        phase;
        int                        n;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(kf_pkg::REG_PROCESS_NOISE, 1'b0, '0);
        apb_access(kf_pkg::REG_MEASUREMENT_NOISE, 1'b0, '0);

        corner = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000};
        foreach (corner[i])
            send_sample(corner[i]);

        // Both noise terms at zero drive the covariance to zero and the gain to one.
        set_noise_pair(32'hFF00_0000, 32'hFF00_0000);
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0000_0000};
        foreach (corner[i])
            send_sample(corner[i]);

        set_noise_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h5555_5555, 32'hAAAA_AAAA};
        foreach (corner[i])
            send_sample(corner[i]);

        set_noise_pair(32'h00FF_FFFF, 32'h0000_0000);
        corner = '{32'h7FFF_FFFF, 32'h8000_0000};
        foreach (corner[i])
            send_sample(corner[i]);

        set_noise_pair(32'h0000_0000, 32'h00FF_FFFF);
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        foreach (corner[i])
            send_sample(corner[i]);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_noise_pair(pick_noise(), pick_noise());
            for (n = 0; n < PHASE_SAMPLES; n++)
            begin
                if (n == PHASE_SAMPLES / 2 || $urandom_range(0, 99) == 0)
                    drain_estimates();
                send_sample(pick_sample());
            end
        end

        drain_estimates();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d samples and %0d estimates over %0d noise settings,",
                 tracker.samples_seen, tracker.estimates_seen, settings_used);
        $display("including zero and full-scale noise and full-scale sample swings.");
        if (tracker.mismatches == 0)
            $display("scalar_kalman_filter_test: PASS");
        else
            $display("scalar_kalman_filter_test: FAIL");
        $finish;
    end

endmodule
